// ----- rtl/core/ksf_pkg.sv -----
// ----------------------------------------------------------------------------
// ksf_pkg
// Shared constants, types and helpers for the keyed state table.
// ----------------------------------------------------------------------------
package ksf_pkg;

	localparam int unsigned CAPACITY_DEF   = 1024;
	localparam int unsigned RING_DEPTH_DEF = 256;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	localparam int unsigned KEY_W   = 32;
	localparam int unsigned ITEMS_W = 8;
	localparam int unsigned WIN_W   = 9;
	localparam int unsigned CNT_W   = 11;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CIDR   = 2'd3
	} op_t;

	localparam logic [ITEMS_W-1:0] ITEMS_MAX = 8'hff;

	function automatic logic [KEY_W-1:0] netmask_of(input logic [KEY_W-1:0] m);
		logic [KEY_W-1:0] r;
		if (m == '0) begin
			r = '0;
		end else if (m > 32'd32) begin
			r = m;
		end else begin
			r = 32'hffff_ffff << (6'd32 - 6'(m));
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/ksf_ram.sv -----
// ----------------------------------------------------------------------------
// ksf_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module ksf_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/ip_keyed_state_table_fifo_evict_unit.sv -----
// ----------------------------------------------------------------------------
// ip_keyed_state_table_fifo_evict_unit
// IPv4 keyed state table with write, read, remove, CIDR count and FIFO eviction.
// ----------------------------------------------------------------------------
// Every request walks the whole table through one compare unit, one entry per
// cycle, and the result is offered once the walk is done. A write that is
// stored while the FIFO window is set also reads its ring slot; if that slot
// holds a key, the table is walked a second time to evict it. One request is in
// flight at a time. After reset a clearing pass zeroes every table entry and
// ring slot before the first request is taken.
module ip_keyed_state_table_fifo_evict_unit #(
	parameter int unsigned CAPACITY   = ksf_pkg::CAPACITY_DEF,
	parameter int unsigned RING_DEPTH = ksf_pkg::RING_DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = ksf_pkg::DATA_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// opcode[1:0], ip_addr[33:2], data_word[65:34], mask[97:66], zero fill
	input  logic [103:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[0], found[1], read_data[33:2], item_count[41:34],
	// host_count[52:42], match_count[63:53]
	output logic [63:0]  m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [8:0]   cfg_data
);

	localparam int unsigned KW  = ksf_pkg::KEY_W;
	localparam int unsigned IW  = ksf_pkg::ITEMS_W;
	localparam int unsigned TW  = 1 + KW + DATA_WIDTH + IW;
	localparam int unsigned TAW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned RAW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned SCW = $clog2(CAPACITY + 1);
	localparam int unsigned CLR = (CAPACITY > RING_DEPTH) ? CAPACITY : RING_DEPTH;
	localparam int unsigned CLW = $clog2(CLR + 1);
	localparam int unsigned WW  = 17;
	localparam int unsigned CW  = ksf_pkg::CNT_W;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_SCAN  = 8'b0000_0100,
		S_APPLY = 8'b0000_1000,
		S_RRD   = 8'b0001_0000,
		S_RWAIT = 8'b0010_0000,
		S_RWR   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [CLW-1:0]        clr_q;
	logic [SCW-1:0]        issue_q;
	logic                  pend_s1;
	logic [TAW-1:0]        idx_s1;
	logic                  evict_q;
	ksf_pkg::op_t          op_q;
	logic [KW-1:0]         ip_q, key_q, nm_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic                  hit_q, free_q;
	logic [TAW-1:0]        hit_idx_q, free_idx_q;
	logic [DATA_WIDTH-1:0] hit_data_q;
	logic [IW-1:0]         hit_items_q;
	logic [SCW-1:0]        match_q, hosts_q;
	logic [8:0]            window_q;
	logic [RAW-1:0]        ptr_q, p_q;
	logic                  status_q, found_q;

	logic                  tab_we;
	logic [TAW-1:0]        tab_waddr;
	logic [TW-1:0]         tab_wdata, tab_rdata;
	logic                  ring_we;
	logic [RAW-1:0]        ring_waddr, ring_raddr;
	logic [KW-1:0]         ring_wdata, ring_rdata;

	logic                  e_valid;
	logic [KW-1:0]         e_key;
	logic [DATA_WIDTH-1:0] e_data;
	logic [IW-1:0]         e_items;
	logic [WW-1:0]         win, p_ext;
	logic [RAW-1:0]        p_sel;

	assign {e_valid, e_key, e_data, e_items} = tab_rdata;

	assign win   = ({8'd0, window_q} > WW'(RING_DEPTH)) ? WW'(RING_DEPTH) : {8'd0, window_q};
	assign p_sel = ({{(WW-RAW){1'b0}}, ptr_q} < win) ? ptr_q : '0;
	assign p_ext = {{(WW-RAW){1'b0}}, p_q} + WW'(1);

	ksf_ram #(.WIDTH(TW), .DEPTH(CAPACITY)) u_tab (
		.clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
		.raddr(issue_q[TAW-1:0]), .rdata(tab_rdata)
	);

	ksf_ram #(.WIDTH(KW), .DEPTH(RING_DEPTH)) u_ring (
		.clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
		.raddr(ring_raddr), .rdata(ring_rdata)
	);

	assign ring_raddr = p_sel;

	always_comb begin
		tab_we     = 1'b0;
		tab_waddr  = hit_idx_q;
		tab_wdata  = {1'b1, ip_q, word_q, hit_items_q};
		ring_we    = 1'b0;
		ring_waddr = p_q;
		ring_wdata = ip_q;
		case (state_q)
			S_CLEAR: begin
				tab_we     = (clr_q < CLW'(CAPACITY));
				tab_waddr  = clr_q[TAW-1:0];
				tab_wdata  = '0;
				ring_we    = (clr_q < CLW'(RING_DEPTH));
				ring_waddr = clr_q[RAW-1:0];
				ring_wdata = '0;
			end
			S_APPLY: begin
				if (evict_q || op_q == ksf_pkg::OP_REMOVE) begin
					tab_we    = hit_q;
					tab_wdata = '0;
				end else if (op_q == ksf_pkg::OP_WRITE) begin
					if (hit_q) begin
						tab_we    = 1'b1;
						tab_wdata = {1'b1, ip_q, word_q,
							(hit_items_q == ksf_pkg::ITEMS_MAX) ? hit_items_q
							                                   : hit_items_q + IW'(1)};
					end else if (free_q) begin
						tab_we    = 1'b1;
						tab_waddr = free_idx_q;
						tab_wdata = {1'b1, ip_q, word_q, IW'(1)};
					end
				end
			end
			S_RWR: begin
				ring_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			issue_q  <= '0;
			pend_s1  <= 1'b0;
			hosts_q  <= '0;
			window_q <= '0;
			ptr_q    <= '0;
			evict_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				window_q <= cfg_data;
			end
			pend_s1 <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CLW'(1);
					if (clr_q == CLW'(CLR - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						op_q     <= ksf_pkg::op_t'(s_tdata[1:0]);
						ip_q     <= s_tdata[33:2];
						key_q    <= s_tdata[33:2];
						word_q   <= DATA_WIDTH'(s_tdata[65:34]);
						nm_q     <= ksf_pkg::netmask_of(s_tdata[97:66]);
						evict_q  <= 1'b0;
						status_q <= 1'b0;
						found_q  <= 1'b0;
						hit_q    <= 1'b0;
						free_q   <= 1'b0;
						match_q  <= '0;
						issue_q  <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue_q < SCW'(CAPACITY)) begin
						issue_q <= issue_q + SCW'(1);
						pend_s1 <= 1'b1;
						idx_s1  <= issue_q[TAW-1:0];
					end
					if (pend_s1) begin
						if (e_valid && e_key == key_q) begin
							hit_q       <= 1'b1;
							hit_idx_q   <= idx_s1;
							hit_data_q  <= e_data;
							hit_items_q <= e_items;
						end
						if (!e_valid && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_s1;
						end
						if (e_valid && ((e_key & nm_q) == (ip_q & nm_q))) begin
							match_q <= match_q + SCW'(1);
						end
						if (idx_s1 == TAW'(CAPACITY - 1)) begin
							state_q <= S_APPLY;
						end
					end
				end
				S_APPLY: begin
					state_q <= S_OUT;
					if (evict_q) begin
						if (hit_q) begin
							hosts_q <= hosts_q - SCW'(1);
						end
						state_q <= S_RWR;
					end else begin
						case (op_q)
							ksf_pkg::OP_WRITE: begin
								if (!hit_q && !free_q) begin
									status_q <= 1'b1;
								end else begin
									if (!hit_q) begin
										hosts_q <= hosts_q + SCW'(1);
									end
									if (window_q != '0) begin
										state_q <= S_RRD;
									end
								end
							end
							ksf_pkg::OP_READ: begin
								found_q <= hit_q;
							end
							ksf_pkg::OP_REMOVE: begin
								found_q <= hit_q;
								if (hit_q) begin
									hosts_q <= hosts_q - SCW'(1);
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RRD: begin
					p_q     <= p_sel;
					state_q <= S_RWAIT;
				end
				S_RWAIT: begin
					if (ring_rdata != '0) begin
						key_q   <= ring_rdata;
						evict_q <= 1'b1;
						hit_q   <= 1'b0;
						issue_q <= '0;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_RWR;
					end
				end
				S_RWR: begin
					ptr_q   <= (p_ext == win) ? '0 : p_ext[RAW-1:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	logic              rd_out;
	logic [KW-1:0]     rdata_out;
	logic [IW-1:0]     items_out;

	assign rd_out    = (op_q == ksf_pkg::OP_READ) && found_q;
	assign rdata_out = rd_out ? KW'(hit_data_q) : '0;
	assign items_out = rd_out ? hit_items_q : '0;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = (state_q == S_OUT);
	assign m_tdata   = {
		(op_q == ksf_pkg::OP_CIDR) ? CW'(match_q) : CW'(0),
		CW'(hosts_q),
		items_out,
		rdata_out,
		found_q,
		status_q
	};

endmodule

// ----- rtl/core/ksf_chk.sv -----
// ----------------------------------------------------------------------------
// ksf_chk
// Port level checks for the keyed state table, bound to the top level.
// ----------------------------------------------------------------------------
module ksf_chk #(
	parameter int unsigned CAPACITY = ksf_pkg::CAPACITY_DEF
) (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [103:0] s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [63:0]  m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("request changed while waiting");

	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("new request taken while a result is pending");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[1] && m_tdata[33:2] == '0)
		else $error("full status with read fields set");

	a_hosts: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && CAPACITY < 2048 |-> m_tdata[52:42] <= 11'(CAPACITY))
		else $error("host count above capacity");

endmodule

bind ip_keyed_state_table_fifo_evict_unit ksf_chk #(.CAPACITY(CAPACITY)) u_ksf_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
